@@ design/stp_pkg.sv @@
// Shared constants, types and codes for the speaker toggle to PCM converter.
package stp_pkg;

	// Field and state widths.
	localparam int unsigned LEN_W     = 8;
	localparam int unsigned SUM_W     = 24;
	localparam int unsigned LEVEL_W   = 16;
	localparam int unsigned FADE_W    = 16;
	localparam int unsigned CFG_DATA_W = 8;

	// Sample length limits.
	localparam int unsigned MAX_CLKS_PER_SAMPLE = 255;
	localparam int unsigned MIN_CLKS            = 8;
	localparam int unsigned CLKS_RESET          = 23;

	// Fade gain constants.
	localparam int unsigned FULL_GAIN   = 32768;
	localparam int unsigned FADE_HOLD   = 10000;
	localparam int unsigned FADE_RELOAD = FULL_GAIN + FADE_HOLD;
	localparam int unsigned FADE_FRAC   = $clog2(FULL_GAIN);

	// Speaker levels.
	localparam logic [LEVEL_W-1:0] LEVEL_INIT  = 16'h8000;
	localparam logic [LEVEL_W-1:0] DRIVE_LOUD  = 16'h8000;
	localparam logic [LEVEL_W-1:0] DRIVE_QUIET = 16'hE000;

	// Divider: quotient bits retired per cycle and cycle count.
	localparam int unsigned BITS_PER_STEP = 4;
	localparam int unsigned DIV_STEPS     = SUM_W / BITS_PER_STEP;
	localparam int unsigned STEP_W        = $clog2(DIV_STEPS);

	// Queue between front and back.
	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);

	// Configuration register indexes.
	typedef enum logic [0:0] {
		REG_CLKS_PER_SAMPLE = 1'b0,
		REG_QUIET_DRIVE     = 1'b1
	} cfg_reg_t;

	// One finished sum handed from front to back.
	typedef struct packed {
		logic signed [SUM_W-1:0] sum;
		logic [LEN_W-1:0]        len;
		logic [FADE_W-1:0]       fade;
	} job_t;

	// Queue status seen by both sides.
	typedef struct packed {
		logic not_empty;
		logic full;
	} q_stat_t;

endpackage

@@ design/stp_if.sv @@
// Handshake channels for toggle beats in and sample beats out.
interface stp_toggle_if;
	logic valid;
	logic ready;
	logic toggle;

	modport source(output valid, output toggle, input ready);
	modport sink(input valid, input toggle, output ready);
endinterface

interface stp_sample_if;
	logic                                valid;
	logic                                ready;
	logic signed [stp_pkg::LEVEL_W-1:0]  sample;

	modport source(output valid, output sample, input ready);
	modport sink(input valid, input sample, output ready);
endinterface

@@ design/speaker_toggle_to_pcm_with_dc_fade.sv @@
// Top level of the speaker toggle to PCM converter with DC fade.
//
//   Channel   Direction  Payload              Beat
//   toggles   in         toggle (1 bit)       one per CPU clock
//   samples   out        sample (16 bit, s)   one per sample length
//   cfg       in         index 1 b, data 8 b  write, no handshake
//
// The front takes one toggle beat every cycle while the queue has room.
// Each sample passes through the back as divider steps at 4 quotient
// bits each, a fade multiply and an output load overlapped with the next.
// With sample lengths of 8 or more the input never stalls unless the
// sample sink holds off; a stalled sink fills the 2-entry queue, then the
// input stalls. Reset is asynchronous and clears all control state.
module speaker_toggle_to_pcm_with_dc_fade (
	input  logic                           clk,
	input  logic                           arst_n,
	stp_toggle_if.sink                     toggles,
	stp_sample_if.source                   samples,
	input  logic                           cfg_we,
	input  stp_pkg::cfg_reg_t              cfg_index,
	input  logic [stp_pkg::CFG_DATA_W-1:0] cfg_data
);
	import stp_pkg::*;

	logic    push;
	logic    pop;
	job_t    job_in;
	job_t    job_out;
	q_stat_t q_stat;

	stp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.toggles   (toggles),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_stat    (q_stat),
		.push      (push),
		.job       (job_in)
	);

	stp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.job_in  (job_in),
		.pop     (pop),
		.job_out (job_out),
		.q_stat  (q_stat)
	);

	stp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_stat  (q_stat),
		.job     (job_out),
		.pop     (pop),
		.samples (samples)
	);

endmodule

@@ design/stp_front.sv @@
// Front part: takes one toggle beat per clock while the queue has room; tracks level, sum and fade counter.
module stp_front (
	input  logic                           clk,
	input  logic                           arst_n,
	stp_toggle_if.sink                     toggles,
	input  logic                           cfg_we,
	input  stp_pkg::cfg_reg_t              cfg_index,
	input  logic [stp_pkg::CFG_DATA_W-1:0] cfg_data,
	input  stp_pkg::q_stat_t               q_stat,
	output logic                           push,
	output stp_pkg::job_t                  job
);
	import stp_pkg::*;

	logic [LEN_W-1:0]        clks_q;
	logic                    quiet_q;
	logic [LEVEL_W-1:0]      level_q;
	logic [LEN_W-1:0]        cnt_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [FADE_W-1:0]       fade_q;

	logic [LEN_W-1:0]        len;
	logic [LEN_W-1:0]        cnt_inc;
	logic signed [SUM_W-1:0] sum_add;
	logic [LEVEL_W-1:0]      drive;
	logic                    accept;
	logic                    emit;

	// Effective sample length, clamped to the legal range.
	always_comb begin
		if (clks_q < LEN_W'(MIN_CLKS)) begin
			len = LEN_W'(MIN_CLKS);
		end else if (clks_q > LEN_W'(MAX_CLKS_PER_SAMPLE)) begin
			len = LEN_W'(MAX_CLKS_PER_SAMPLE);
		end else begin
			len = clks_q;
		end
	end

	// The level before any toggle on this clock goes into the sum.
	assign sum_add = sum_q + {{(SUM_W-LEVEL_W){level_q[LEVEL_W-1]}}, level_q};
	assign cnt_inc = cnt_q + LEN_W'(1);
	assign emit    = (cnt_inc >= len);
	assign drive   = quiet_q ? DRIVE_QUIET : DRIVE_LOUD;

	assign toggles.ready = !q_stat.full;
	assign accept        = toggles.valid && toggles.ready;
	assign push          = accept && emit;

	// The job carries the fade counter as it stands before this clock's update.
	assign job.sum  = sum_add;
	assign job.len  = len;
	assign job.fade = fade_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clks_q  <= LEN_W'(CLKS_RESET);
			quiet_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CLKS_PER_SAMPLE: clks_q  <= cfg_data[LEN_W-1:0];
				REG_QUIET_DRIVE:     quiet_q <= cfg_data[0];
				default:             ;
			endcase
		end
	end

	// Sum and clock count for the sample in progress.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (accept) begin
			if (emit) begin
				sum_q <= '0;
				cnt_q <= '0;
			end else begin
				sum_q <= sum_add;
				cnt_q <= cnt_inc;
			end
		end
	end

	// Fade counter: reload on a toggle, otherwise count down once per sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_q <= '0;
		end else if (accept) begin
			if (toggles.toggle) begin
				fade_q <= FADE_W'(FADE_RELOAD);
			end else if (emit && (fade_q != '0)) begin
				fade_q <= fade_q - FADE_W'(1);
			end
		end
	end

	// Speaker level flips between the drive level and its inverse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= LEVEL_INIT;
		end else if (accept && toggles.toggle) begin
			if (level_q == drive) begin
				level_q <= ~drive;
			end else begin
				level_q <= drive;
			end
		end
	end

endmodule

@@ design/stp_queue.sv @@
// Short queue of finished sums between the front and back parts.
module stp_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  stp_pkg::job_t    job_in,
	input  logic             pop,
	output stp_pkg::job_t    job_out,
	output stp_pkg::q_stat_t q_stat
);
	import stp_pkg::*;

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QPTR_W:0]   count_q;

	assign q_stat.not_empty = (count_q != '0);
	assign q_stat.full      = (count_q == (QPTR_W+1)'(QDEPTH));
	assign job_out          = mem_q[rptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= job_in;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QPTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QPTR_W+1)'(1);
			end
		end
	end

endmodule

@@ design/stp_back.sv @@
// Back part: divides each sum by its length, applies the fade and drives samples.
module stp_back (
	input  logic             clk,
	input  logic             arst_n,
	input  stp_pkg::q_stat_t q_stat,
	input  stp_pkg::job_t    job,
	output logic             pop,
	stp_sample_if.source     samples
);
	import stp_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_DIV  = 4'b0010,
		S_MUL  = 4'b0100,
		S_PUT  = 4'b1000
	} state_t;

	state_t                    state_q;
	logic [SUM_W-1:0]          dvd_q;
	logic [LEN_W-1:0]          rem_q;
	logic [LEN_W-1:0]          len_q;
	logic [FADE_W-1:0]         fade_q;
	logic                      neg_q;
	logic [STEP_W-1:0]         step_q;
	logic [LEVEL_W-1:0]        mag_q;
	logic                      out_vld_q;
	logic [LEVEL_W-1:0]        out_smp_q;

	logic                      put_ok;
	logic                      load;
	logic [SUM_W-1:0]          sum_abs;
	logic [SUM_W-1:0]          dvd_nxt;
	logic [LEN_W-1:0]          rem_nxt;
	logic [LEN_W:0]            trial;
	logic [LEVEL_W+FADE_W-2:0] prod;
	logic [LEVEL_W-1:0]        mag_nxt;

	assign put_ok  = !out_vld_q || samples.ready;
	assign load    = q_stat.not_empty &&
		((state_q == S_IDLE) || ((state_q == S_PUT) && put_ok));
	assign pop     = load;
	assign sum_abs = job.sum[SUM_W-1] ? SUM_W'(-job.sum) : SUM_W'(job.sum);

	assign samples.valid  = out_vld_q;
	assign samples.sample = out_smp_q;

	// Restoring division, several quotient bits per cycle.
	always_comb begin
		rem_nxt = rem_q;
		dvd_nxt = dvd_q;
		trial   = '0;
		for (int k = 0; k < BITS_PER_STEP; k++) begin
			trial   = {rem_nxt, dvd_nxt[SUM_W-1]};
			dvd_nxt = {dvd_nxt[SUM_W-2:0], 1'b0};
			if (trial >= {1'b0, len_q}) begin
				trial      = trial - {1'b0, len_q};
				dvd_nxt[0] = 1'b1;
			end
			rem_nxt = trial[LEN_W-1:0];
		end
	end

	// Fade gain on the mean magnitude.
	assign prod = (LEVEL_W+FADE_W-1)'(dvd_q[LEVEL_W-1:0]) *
		(LEVEL_W+FADE_W-1)'(fade_q[FADE_W-2:0]);

	always_comb begin
		if (fade_q == '0) begin
			mag_nxt = '0;
		end else if (fade_q >= FADE_W'(FULL_GAIN)) begin
			mag_nxt = dvd_q[LEVEL_W-1:0];
		end else begin
			mag_nxt = prod[FADE_FRAC +: LEVEL_W];
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (load) begin
						state_q <= S_DIV;
						step_q  <= '0;
					end
				end
				S_DIV: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(DIV_STEPS - 1)) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_PUT;
				end
				S_PUT: begin
					if (load) begin
						state_q <= S_DIV;
						step_q  <= '0;
					end else if (put_ok) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (load) begin
			dvd_q  <= sum_abs;
			rem_q  <= '0;
			len_q  <= job.len;
			fade_q <= job.fade;
			neg_q  <= job.sum[SUM_W-1];
		end else if (state_q == S_DIV) begin
			dvd_q <= dvd_nxt;
			rem_q <= rem_nxt;
		end
		if (state_q == S_MUL) begin
			mag_q <= mag_nxt;
		end
	end

	// Output register: holds a finished sample until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if ((state_q == S_PUT) && put_ok) begin
			out_vld_q <= 1'b1;
		end else if (samples.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_PUT) && put_ok) begin
			out_smp_q <= neg_q ? LEVEL_W'(-mag_q) : mag_q;
		end
	end

endmodule

@@ design/stp_check.sv @@
// Port-level checker for the converter top level, with its bind.
module stp_check (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic signed [stp_pkg::LEVEL_W-1:0]  out_sample
);
	import stp_pkg::*;

	// A sample beat that is not taken stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("sample beat dropped while stalled");

	// A stalled sample keeps its value.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_sample))
		else $error("sample changed while stalled");

	// The input can only close after a beat was taken that filled the queue.
	a_ready_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(in_valid && in_ready))
		else $error("input stalled without a preceding beat");

	// The handshake outputs always carry a defined level out of reset.
	a_ctrl_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({in_ready, out_valid}))
		else $error("handshake output undefined");

endmodule

bind speaker_toggle_to_pcm_with_dc_fade stp_check u_stp_check (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (toggles.valid),
	.in_ready   (toggles.ready),
	.out_valid  (samples.valid),
	.out_ready  (samples.ready),
	.out_sample (samples.sample)
);
